@@ rtl/mihp_pkg.sv @@
// Shared types and constants for the image header element parser.
package mihp_pkg;

  localparam int PREAMBLE_BYTES_DEF = 128;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_PASS_ALL      = 2'd0;
  localparam logic [1:0] REG_MATCH_GROUP   = 2'd1;
  localparam logic [1:0] REG_MATCH_ELEMENT = 2'd2;

  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_VALUE     = 2'd1;
  localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;

  localparam logic [31:0] MAGIC_WORD   = 32'h4449_434D; // "DICM"
  localparam logic [31:0] UNDEF_LENGTH = 32'hFFFF_FFFF;
  localparam logic [15:0] VR_IMPLICIT  = 16'hFFFF;
  localparam logic [7:0]  GROUP_IMPL_HI = 8'hFF;
  localparam logic [15:0] VR_OB = 16'h4F42;
  localparam logic [15:0] VR_OW = 16'h4F57;
  localparam logic [15:0] VR_SQ = 16'h5351;
  localparam logic [15:0] VR_UN = 16'h554E;

  localparam int OUT_TDATA_W = 88;

  typedef struct packed {
    logic        pass_all;
    logic [15:0] match_group;
    logic [15:0] match_element;
  } mihp_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } mihp_in_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] tag_group;
    logic [15:0] tag_element;
    logic [15:0] vr_code;
    logic [31:0] value_length;
    logic [7:0]  value_byte;
    logic        last_value;
  } mihp_res_t;

  function automatic logic vr_is_long(input logic [15:0] vr);
    return (vr == VR_OB) || (vr == VR_OW) || (vr == VR_SQ) || (vr == VR_UN);
  endfunction

endpackage

@@ rtl/mihp_cfg.sv @@
// APB register file: pass_all, match_group, match_element.
module mihp_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mihp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mihp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mihp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output mihp_pkg::mihp_cfg_t                cfg
);
  import mihp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pass_all      <= 1'b1;
      cfg.match_group   <= 16'h0000;
      cfg.match_element <= 16'h0000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PASS_ALL:      cfg.pass_all      <= pwdata[0];
        REG_MATCH_GROUP:   cfg.match_group   <= pwdata[15:0];
        REG_MATCH_ELEMENT: cfg.match_element <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PASS_ALL:      prdata = {31'b0, cfg.pass_all};
      REG_MATCH_GROUP:   prdata = {16'b0, cfg.match_group};
      REG_MATCH_ELEMENT: prdata = {16'b0, cfg.match_element};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/mihp_step.sv @@
// Parse state registers and the next-state and result logic, one byte per cycle while advance is high.
module mihp_step #(
  parameter int PREAMBLE_BYTES = mihp_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  mihp_pkg::mihp_in_t  in_beat,
  input  mihp_pkg::mihp_cfg_t cfg,
  output mihp_pkg::mihp_res_t res
);
  import mihp_pkg::*;

  localparam logic [3:0] PH_PREAMBLE = 4'd0;
  localparam logic [3:0] PH_MAGIC    = 4'd1;
  localparam logic [3:0] PH_IDLE     = 4'd2;
  localparam logic [3:0] PH_GROUP    = 4'd3;
  localparam logic [3:0] PH_ELEMENT  = 4'd4;
  localparam logic [3:0] PH_VR       = 4'd5;
  localparam logic [3:0] PH_RESERVED = 4'd6;
  localparam logic [3:0] PH_LEN2     = 4'd7;
  localparam logic [3:0] PH_LEN4     = 4'd8;
  localparam logic [3:0] PH_VALUE    = 4'd9;
  localparam logic [3:0] PH_START = (PREAMBLE_BYTES == 0) ? PH_MAGIC : PH_PREAMBLE;
  localparam logic [31:0] PRE_LEN = 32'(PREAMBLE_BYTES);

  logic [3:0]  phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [15:0] cur_group, cur_group_next;
  logic [15:0] cur_element, cur_element_next;
  logic [15:0] cur_vr, cur_vr_next;
  logic [31:0] cur_length, cur_length_next;
  logic        wanted, wanted_next;

  // state as seen by this beat, after a possible new-file restart
  logic [3:0]  ph;
  logic [31:0] cnt, cnt_inc, len4;
  logic [15:0] grp, ele, vr;
  logic [31:0] len;
  logic        want, last;
  logic [7:0]  b;

  always_comb begin
    b    = in_beat.data_byte;
    ph   = phase;
    cnt  = byte_count;
    grp  = cur_group;
    ele  = cur_element;
    vr   = cur_vr;
    len  = cur_length;
    want = wanted;
    if (in_beat.new_file) begin
      ph   = PH_START;
      cnt  = '0;
      grp  = '0;
      ele  = '0;
      vr   = '0;
      len  = '0;
      want = 1'b0;
    end
    cnt_inc = cnt + 32'd1;
    len4    = len;
    last    = 1'b0;

    phase_next       = ph;
    byte_count_next  = cnt;
    cur_group_next   = grp;
    cur_element_next = ele;
    cur_vr_next      = vr;
    cur_length_next  = len;
    wanted_next      = want;
    res              = '0;

    case (ph)
      PH_PREAMBLE: begin
        if (cnt_inc >= PRE_LEN) begin
          phase_next      = PH_MAGIC;
          byte_count_next = '0;
          cur_length_next = '0;
        end else begin
          byte_count_next = cnt_inc;
        end
      end
      PH_MAGIC: begin
        cur_length_next = {len[23:0], b};
        if (cnt_inc < 32'd4) begin
          byte_count_next = cnt_inc;
        end else begin
          byte_count_next = '0;
          if ({len[23:0], b} != MAGIC_WORD) begin
            phase_next       = PH_IDLE;
            cur_length_next  = '0;
            cur_group_next   = '0;
            cur_element_next = '0;
            cur_vr_next      = '0;
            res.valid        = 1'b1;
            res.kind         = KIND_BAD_MAGIC;
          end else begin
            cur_length_next = '0;
            phase_next      = PH_GROUP;
          end
        end
      end
      PH_GROUP: begin
        if (cnt == 32'd0) begin
          cur_group_next  = {8'h00, b};
          byte_count_next = 32'd1;
        end else begin
          cur_group_next  = {b, grp[7:0]};
          byte_count_next = '0;
          phase_next      = PH_ELEMENT;
        end
      end
      PH_ELEMENT: begin
        if (cnt == 32'd0) begin
          cur_element_next = {8'h00, b};
          byte_count_next  = 32'd1;
        end else begin
          cur_element_next = {b, ele[7:0]};
          byte_count_next  = '0;
          cur_length_next  = '0;
          if (grp[15:8] == GROUP_IMPL_HI) begin
            cur_vr_next = VR_IMPLICIT;
            phase_next  = PH_LEN4;
          end else begin
            phase_next  = PH_VR;
          end
        end
      end
      PH_VR: begin
        if (cnt == 32'd0) begin
          cur_vr_next     = {b, 8'h00};
          byte_count_next = 32'd1;
        end else begin
          cur_vr_next     = {vr[15:8], b};
          byte_count_next = '0;
          phase_next      = vr_is_long({vr[15:8], b}) ? PH_RESERVED : PH_LEN2;
        end
      end
      PH_RESERVED: begin
        if (cnt_inc >= 32'd2) begin
          byte_count_next = '0;
          phase_next      = PH_LEN4;
        end else begin
          byte_count_next = cnt_inc;
        end
      end
      PH_LEN2, PH_LEN4: begin
        if (ph == PH_LEN2) begin
          len4 = cnt[0] ? (len | {16'h0000, b, 8'h00}) : (len | {24'h000000, b});
        end else begin
          case (cnt[1:0])
            2'd0:    len4 = len | {24'h000000, b};
            2'd1:    len4 = len | {16'h0000, b, 8'h00};
            2'd2:    len4 = len | {8'h00, b, 16'h0000};
            default: len4 = len | {b, 24'h000000};
          endcase
        end
        cur_length_next = len4;
        if (cnt_inc < ((ph == PH_LEN2) ? 32'd2 : 32'd4)) begin
          byte_count_next = cnt_inc;
        end else begin
          if (ph == PH_LEN4 && len4 == UNDEF_LENGTH) begin
            len4 = '0;
          end
          cur_length_next = len4;
          wanted_next     = cfg.pass_all ||
                            (grp == cfg.match_group && ele == cfg.match_element);
          byte_count_next = '0;
          phase_next      = (len4 == 32'd0) ? PH_GROUP : PH_VALUE;
          res.valid        = 1'b1;
          res.kind         = KIND_HEADER;
          res.tag_group    = grp;
          res.tag_element  = ele;
          res.vr_code      = vr;
          res.value_length = len4;
        end
      end
      PH_VALUE: begin
        last = (cnt_inc >= len);
        if (last) begin
          phase_next      = PH_GROUP;
          byte_count_next = '0;
        end else begin
          byte_count_next = cnt_inc;
        end
        if (want) begin
          res.valid        = 1'b1;
          res.kind         = KIND_VALUE;
          res.tag_group    = grp;
          res.tag_element  = ele;
          res.vr_code      = vr;
          res.value_length = len;
          res.value_byte   = b;
          res.last_value   = last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      byte_count  <= '0;
      cur_group   <= '0;
      cur_element <= '0;
      cur_vr      <= '0;
      cur_length  <= '0;
      wanted      <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      cur_group   <= cur_group_next;
      cur_element <= cur_element_next;
      cur_vr      <= cur_vr_next;
      cur_length  <= cur_length_next;
      wanted      <= wanted_next;
    end
  end

endmodule

@@ rtl/medical_image_header_element_parser.sv @@
// A byte accepted on the slave side passes the input register, then the output register,
// to the master side. Throughput: one byte per cycle; the parse step is combinational
// between the two, and a full input register holds its byte while a result waits.
// Reset (rst, synchronous): empties both registers, clears the parse state to the preamble
// phase (magic if PREAMBLE_BYTES = 0) and loads pass_all = 1, match_group = 0, match_element = 0.
module medical_image_header_element_parser #(
  parameter int PREAMBLE_BYTES = mihp_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // data_byte
  input  logic [0:0]                           s_tuser,   // new_file
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // tag_group, tag_element, vr_code, value_length, value_byte
  output logic [mihp_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic [1:0]                           m_tuser,   // kind
  output logic                                 m_tlast,   // last_value
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mihp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mihp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mihp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import mihp_pkg::*;

  mihp_cfg_t cfg;
  mihp_in_t  in_beat;
  mihp_res_t res;
  logic      in_vld;
  logic      advance;

  // parse the held beat when the output register is free or draining
  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_beat.data_byte <= s_tdata;
      in_beat.new_file  <= s_tuser[0];
    end
  end

  mihp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mihp_step #(
    .PREAMBLE_BYTES (PREAMBLE_BYTES)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_beat (in_beat),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {res.value_byte, res.value_length, res.vr_code,
                  res.tag_element, res.tag_group};
      m_tuser <= res.kind;
      m_tlast <= res.last_value;
    end
  end

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_vld && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input register overwritten while output stalled");

  a_bad_magic_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_BAD_MAGIC) |-> (m_tdata == '0 && !m_tlast))
    else $error("bad magic beat carries element fields");

  a_header_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_HEADER) |-> (!m_tlast && m_tdata[87:80] == 8'h00))
    else $error("header beat carries value byte fields");

  a_no_result_without_beat: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && !advance) |=> !m_tvalid)
    else $error("result appeared without a parsed byte");

endmodule
